// ----- rtl/core/whp_pkg.sv -----
package whp_pkg;

  localparam int unsigned TABLE_SLOTS_DEF    = 1024;
  localparam int unsigned MAX_WORD_CHARS_DEF = 32;

  localparam logic [31:0] HASH_SEED  = 32'd5381;
  localparam int unsigned HASH_SHIFT = 5;
  localparam int unsigned SLOT_OUT_W = 10;
  localparam int unsigned DIV_STEPS  = 3;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISS     = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_DIV,
    B_READ,
    B_CHECK,
    B_DONE
  } back_state_e;

  typedef struct packed {
    logic                  found;
    logic                  inserted;
    status_e               status;
    logic [SLOT_OUT_W-1:0] slot;
  } res_t;

endpackage

// ----- rtl/core/whp_ram.sv -----
module whp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ----- rtl/core/whp_queue.sv -----
module whp_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_q, wr_d, rd_q, rd_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/core/whp_front.sv -----
module whp_front #(
  parameter int unsigned MAX_WORD_CHARS = whp_pkg::MAX_WORD_CHARS_DEF,
  localparam int unsigned WORD_W = MAX_WORD_CHARS * 8,
  localparam int unsigned JOB_W  = WORD_W + 34
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic             action_i,
  input  logic [7:0]       char_code_i,
  input  logic             last_char_i,
  input  logic             busy_i,
  input  logic             job_full_i,
  output logic             job_push_o,
  output logic [JOB_W-1:0] job_data_o
);

  localparam int unsigned LEN_W = $clog2(MAX_WORD_CHARS + 2);

  logic [31:0]       hash_q, hash_d, hash_n;
  logic [LEN_W-1:0]  len_q, len_d, len_n;
  logic [WORD_W-1:0] buf_q, buf_n, word_m;
  logic              acc;

  assign full_o     = job_full_i || busy_i;
  assign acc        = push_i && !full_o;
  assign job_push_o = acc && last_char_i;

  always_comb begin
    hash_n = hash_q;
    len_n  = len_q;
    buf_n  = buf_q;
    if (char_code_i != 8'd0) begin
      hash_n = (hash_q << whp_pkg::HASH_SHIFT) + hash_q + 32'(char_code_i);
      for (int i = 0; i < MAX_WORD_CHARS; i++) begin
        if (len_q == LEN_W'(i)) begin
          buf_n[i*8 +: 8] = char_code_i;
        end
      end
      if (len_q <= LEN_W'(MAX_WORD_CHARS)) begin
        len_n = len_q + LEN_W'(1);
      end
    end
    // zero pad past the word end
    for (int i = 0; i < MAX_WORD_CHARS; i++) begin
      word_m[i*8 +: 8] = (LEN_W'(i) < len_n) ? buf_n[i*8 +: 8] : 8'd0;
    end
    hash_d = hash_q;
    len_d  = len_q;
    if (acc) begin
      hash_d = last_char_i ? whp_pkg::HASH_SEED : hash_n;
      len_d  = last_char_i ? '0 : len_n;
    end
  end

  assign job_data_o = {action_i, (len_n > LEN_W'(MAX_WORD_CHARS)), hash_n, word_m};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= whp_pkg::HASH_SEED;
      len_q  <= '0;
    end else begin
      hash_q <= hash_d;
      len_q  <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      buf_q <= buf_n;
    end
  end

endmodule

// ----- rtl/core/whp_back.sv -----
module whp_back #(
  parameter int unsigned TABLE_SLOTS    = whp_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned MAX_WORD_CHARS = whp_pkg::MAX_WORD_CHARS_DEF,
  localparam int unsigned WORD_W = MAX_WORD_CHARS * 8,
  localparam int unsigned JOB_W  = WORD_W + 34
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_empty_i,
  input  logic [JOB_W-1:0] job_data_i,
  output logic             job_pop_o,
  output logic             busy_o,
  input  logic             pop_i,
  output logic             res_valid_o,
  output whp_pkg::res_t    res_o
);

  localparam int unsigned SLOT_W = $clog2(TABLE_SLOTS);
  localparam int unsigned ROW_W  = WORD_W + 1;
  localparam int unsigned STEP_W = $clog2(whp_pkg::DIV_STEPS);
  // reciprocal of the table size, rounded up, scaled by 2^(32 + ceil(log2 slots))
  localparam int unsigned REC_SH = 32 + $clog2(TABLE_SLOTS);
  localparam logic [32:0] RECIP  =
    33'(((64'd1 << REC_SH) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS));

  whp_pkg::back_state_e state_q, state_d;
  logic [SLOT_W-1:0]    cnt_q, cnt_d, idx_q, idx_d;
  logic [STEP_W-1:0]    step_q, step_d;
  logic [31:0]          mag_q, mag_d;
  logic [64:0]          prod_q, prod_d;
  logic [31:0]          qd_q, qd_d, quo;
  whp_pkg::res_t        pend_q, pend_d, res_q, res_d;
  logic                 res_valid_q, res_valid_d;

  logic              job_act, job_long;
  logic [31:0]       job_hash;
  logic [WORD_W-1:0] job_word;

  logic              ram_we;
  logic [SLOT_W-1:0] ram_addr;
  logic [ROW_W-1:0]  ram_wdata, ram_rdata;

  assign job_act  = job_data_i[JOB_W-1];
  assign job_long = job_data_i[JOB_W-2];
  assign job_hash = job_data_i[WORD_W +: 32];
  assign job_word = job_data_i[WORD_W-1:0];

  // quotient of the magnitude by the table size
  assign quo = 32'(prod_q >> REC_SH);

  whp_ram #(
    .WIDTH(ROW_W),
    .DEPTH(TABLE_SLOTS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign busy_o      = (state_q == whp_pkg::B_CLEAR);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    step_d      = step_q;
    mag_d       = mag_q;
    prod_d      = prod_q;
    qd_d        = qd_q;
    pend_d      = pend_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !pop_i;
    job_pop_o   = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = idx_q;
    ram_wdata   = {1'b1, job_word};
    unique case (state_q)
      whp_pkg::B_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = cnt_q;
        ram_wdata = '0;
        cnt_d     = cnt_q + SLOT_W'(1);
        if (cnt_q == SLOT_W'(TABLE_SLOTS - 1)) begin
          state_d = whp_pkg::B_IDLE;
        end
      end
      whp_pkg::B_IDLE: begin
        if (!job_empty_i) begin
          pend_d = '0;
          if (job_long) begin
            pend_d.status = whp_pkg::ST_TOO_LONG;
            state_d       = whp_pkg::B_DONE;
          end else begin
            mag_d   = job_hash[31] ? (32'd0 - job_hash) : job_hash;
            step_d  = '0;
            state_d = whp_pkg::B_DIV;
          end
        end
      end
      whp_pkg::B_DIV: begin
        // remainder: reciprocal multiply, multiply back, subtract
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(0)) begin
          prod_d = 65'(mag_q) * 65'(RECIP);
        end else if (step_q == STEP_W'(1)) begin
          qd_d = quo * 32'(TABLE_SLOTS);
        end else begin
          idx_d   = SLOT_W'(mag_q - qd_q);
          cnt_d   = '0;
          state_d = whp_pkg::B_READ;
        end
      end
      whp_pkg::B_READ: begin
        state_d = whp_pkg::B_CHECK;
      end
      whp_pkg::B_CHECK: begin
        priority if (!ram_rdata[ROW_W-1]) begin
          if (job_act == whp_pkg::ACT_INSERT) begin
            ram_we          = 1'b1;
            pend_d.inserted = 1'b1;
            pend_d.slot     = whp_pkg::SLOT_OUT_W'(idx_q);
          end
          state_d = whp_pkg::B_DONE;
        end else if (job_act == whp_pkg::ACT_LOOKUP &&
                     ram_rdata[WORD_W-1:0] == job_word) begin
          pend_d.found = 1'b1;
          pend_d.slot  = whp_pkg::SLOT_OUT_W'(idx_q);
          state_d      = whp_pkg::B_DONE;
        end else if (cnt_q == SLOT_W'(TABLE_SLOTS - 1)) begin
          pend_d.status = whp_pkg::ST_MISS;
          state_d       = whp_pkg::B_DONE;
        end else begin
          cnt_d   = cnt_q + SLOT_W'(1);
          idx_d   = (idx_q == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : idx_q + SLOT_W'(1);
          state_d = whp_pkg::B_READ;
        end
      end
      whp_pkg::B_DONE: begin
        if (!res_valid_q || pop_i) begin
          res_d       = pend_q;
          res_valid_d = 1'b1;
          job_pop_o   = 1'b1;
          state_d     = whp_pkg::B_IDLE;
        end
      end
      default: begin
        state_d = whp_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= whp_pkg::B_CLEAR;
      cnt_q       <= '0;
      step_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      step_q      <= step_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    mag_q  <= mag_d;
    prod_q <= prod_d;
    qd_q   <= qd_d;
    pend_q <= pend_d;
    res_q  <= res_d;
  end

endmodule

// ----- rtl/core/word_hash_set_linear_probe_top.sv -----
// channel  | handshake      | payload
// ---------+----------------+------------------------------------------
// input    | push / full    | action_i, char_code_i, last_char_i
// result   | empty / pop    | found_o, inserted_o, status_o, slot_o
//
// front end takes one character word per cycle while full is low and hashes it on the fly
// each finished word goes into a two-entry job queue; front stalls when it is full or while the table is cleared
// back end per word: dispatch, remainder (reciprocal multiply,
//   multiply back, subtract), probes (table ram registered read, then check),
//   then the result register, held while an earlier result waits for pop
// after reset the back end clears the used bits of every slot, full held high
// a word that is too long still takes a queue entry but skips the divide and probing
module word_hash_set_linear_probe_top #(
  parameter int unsigned TABLE_SLOTS    = whp_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned MAX_WORD_CHARS = whp_pkg::MAX_WORD_CHARS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic       action_i,
  input  logic [7:0] char_code_i,
  input  logic       last_char_i,
  output logic       empty,
  input  logic       pop,
  output logic       found_o,
  output logic       inserted_o,
  output logic [1:0] status_o,
  output logic [9:0] slot_o
);

  localparam int unsigned JOB_W = MAX_WORD_CHARS * 8 + 34;

  // job queue between front and back
  logic             job_push, job_full, job_pop, job_empty, busy;
  logic [JOB_W-1:0] job_in, job_out;

  // result register
  logic          res_valid;
  whp_pkg::res_t res;

  whp_front #(
    .MAX_WORD_CHARS(MAX_WORD_CHARS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .action_i   (action_i),
    .char_code_i(char_code_i),
    .last_char_i(last_char_i),
    .busy_i     (busy),
    .job_full_i (job_full),
    .job_push_o (job_push),
    .job_data_o (job_in)
  );

  whp_queue #(
    .WIDTH(JOB_W)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .data_i (job_in),
    .full_o (job_full),
    .pop_i  (job_pop),
    .empty_o(job_empty),
    .data_o (job_out)
  );

  whp_back #(
    .TABLE_SLOTS   (TABLE_SLOTS),
    .MAX_WORD_CHARS(MAX_WORD_CHARS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_empty_i(job_empty),
    .job_data_i (job_out),
    .job_pop_o  (job_pop),
    .busy_o     (busy),
    .pop_i      (pop),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  assign empty      = !res_valid;
  assign found_o    = res.found;
  assign inserted_o = res.inserted;
  assign status_o   = res.status;
  assign slot_o     = res.slot;

`ifndef SYNTH
  // no result can appear while the table is still being cleared
  a_no_res_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> empty)
    else $error("result during clear pass");

  // a job leaves the queue only when the result register can take it
  a_pop_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |-> (!job_empty && (empty || pop)))
    else $error("job retired without room");

  // found and inserted exclude each other and imply ok status
  a_res_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (found_o || inserted_o)) |->
      (!(found_o && inserted_o) && status_o == whp_pkg::ST_OK))
    else $error("inconsistent result flags");

  // every retired job fills the result register next cycle
  a_pop_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |=> !empty)
    else $error("retired job left no result");
`endif

endmodule
